// ===== rtl/core/bbc_pkg.sv =====
// shared types, character constants and bracket decode for the bracket checker
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    localparam int CH_W    = 8;
    localparam int COUNT_W = 9;
    localparam int CODE_W  = 2;

    typedef logic [CH_W-1:0]    t_char;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CODE_W-1:0]  t_code;

    // quoting state of the scanner
    typedef enum logic [1:0] {
        Q_NONE,
        Q_DOUBLE,
        Q_SINGLE
    } t_quote;

    localparam t_code CODE_NONE  = 2'd0;
    localparam t_code CODE_BRACE = 2'd1;
    localparam t_code CODE_BRACK = 2'd2;
    localparam t_code CODE_PAREN = 2'd3;

    localparam t_char CH_LBRACE = 8'h7B;
    localparam t_char CH_LBRACK = 8'h5B;
    localparam t_char CH_LPAREN = 8'h28;
    localparam t_char CH_RBRACE = 8'h7D;
    localparam t_char CH_RBRACK = 8'h5D;
    localparam t_char CH_RPAREN = 8'h29;
    localparam t_char CH_DQUOTE = 8'h22;
    localparam t_char CH_SQUOTE = 8'h27;

    localparam int COUNT_MAX = 511;

    function automatic t_code opener_code(input t_char c);
        t_code code;
        case (c)
            CH_LBRACE: code = CODE_BRACE;
            CH_LBRACK: code = CODE_BRACK;
            CH_LPAREN: code = CODE_PAREN;
            default:   code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic t_code closer_code(input t_char c);
        t_code code;
        case (c)
            CH_RBRACE: code = CODE_BRACE;
            CH_RBRACK: code = CODE_BRACK;
            CH_RPAREN: code = CODE_PAREN;
            default:   code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbc_ifs.sv =====
// valid/ready channel interfaces for text bytes in and check results out
`timescale 1ns / 1ps
`default_nettype none

interface bbc_byte_if import bbc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char ch;
    logic  last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bbc_result_if import bbc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_count open_count;
    logic   balanced;
    logic   overflowed;

    modport source (output valid, output open_count, output balanced, output overflowed,
                    input ready);
    modport sink   (input valid, input open_count, input balanced, input overflowed,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bracket_balance_checker.sv =====
// bracket balance checker: one text byte per cycle while ready, opener stack held in a ram
// throughput: one byte per cycle while ready, pushes and pops back to back; the top of
// stack sits in a register and the ram read port prefetches the entry below it every cycle
// the result of a last byte is registered and on the output in the cycle after it is taken
// reset (synchronous, active low) empties the stack and clears quote and overflow state;
// the stack ram itself is not cleared, no clearing pass, items are taken straight away
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker import bbc_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    bbc_byte_if.sink      i_byte,
    bbc_result_if.source  o_res
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    logic [SP_W-1:0] r_sp, n_sp;
    t_code           r_top, n_top;
    t_quote          r_quote, n_quote;
    logic            r_ovf, n_ovf;

    logic            r_out_valid;
    t_count          r_out_count;
    logic            r_out_bal;
    logic            r_out_ovf;

    logic            fire;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [SP_W-1:0] rd_sp;
    t_code           below_top;
    t_code           op_code;
    t_code           cl_code;
    logic [31:0]     sp_ext;
    t_count          res_count;
    logic            res_bal;
    logic            res_ovf;

    // non-final bytes never need the result register
    assign i_byte.ready = !i_byte.last || !r_out_valid || o_res.ready;
    assign fire         = i_byte.valid && i_byte.ready;

    assign op_code = opener_code(i_byte.ch);
    assign cl_code = closer_code(i_byte.ch);

    always_comb begin
        n_sp    = r_sp;
        n_top   = r_top;
        n_quote = r_quote;
        n_ovf   = r_ovf;
        ram_we  = 1'b0;
        if (fire) begin
            case (r_quote)
                Q_DOUBLE: begin
                    if (i_byte.ch == CH_DQUOTE) begin
                        n_quote = Q_NONE;
                    end
                end
                Q_SINGLE: begin
                    if (i_byte.ch == CH_SQUOTE) begin
                        n_quote = Q_NONE;
                    end
                end
                default: begin
                    if (i_byte.ch == CH_DQUOTE) begin
                        n_quote = Q_DOUBLE;
                    end else if (i_byte.ch == CH_SQUOTE) begin
                        n_quote = Q_SINGLE;
                    end else if (op_code != CODE_NONE) begin
                        if (r_sp != SP_W'(STACK_DEPTH)) begin
                            ram_we = 1'b1;
                            n_sp   = r_sp + SP_W'(1);
                            n_top  = op_code;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (cl_code != CODE_NONE && r_sp != '0 && r_top == cl_code) begin
                        // entry below the top was prefetched last cycle
                        n_sp  = r_sp - SP_W'(1);
                        n_top = below_top;
                    end
                end
            endcase
        end

        // result reflects the byte just processed
        sp_ext    = 32'(n_sp);
        res_count = (sp_ext > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : sp_ext[COUNT_W-1:0];
        res_bal   = (n_sp == '0) && !n_ovf;
        res_ovf   = n_ovf;

        if (fire && i_byte.last) begin
            n_sp    = '0;
            n_quote = Q_NONE;
            n_ovf   = 1'b0;
        end
    end

    // keep the read port on the entry just below the coming top
    assign rd_sp     = n_sp - SP_W'(2);
    assign ram_raddr = rd_sp[AW-1:0];
    assign ram_waddr = r_sp[AW-1:0];

    bbc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (op_code),
        .i_raddr (ram_raddr),
        .o_rdata (below_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_quote     <= Q_NONE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp    <= n_sp;
            r_quote <= n_quote;
            r_ovf   <= n_ovf;
            if (fire && i_byte.last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (fire && i_byte.last) begin
            r_out_count <= res_count;
            r_out_bal   <= res_bal;
            r_out_ovf   <= res_ovf;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.open_count = r_out_count;
    assign o_res.balanced   = r_out_bal;
    assign o_res.overflowed = r_out_ovf;

endmodule

`default_nettype wire

// ===== rtl/core/bbc_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
